/* src/vcsg_pkg.sv */
// ----------------------------------------------------------------------------
// vcsg_pkg
// shared types and constants of the visual crypto share generator
// ----------------------------------------------------------------------------
package vcsg_pkg;

    // luma weights in units of 1/10000, threshold 127 scaled the same way
    localparam int unsigned LUMA_WEIGHT_RED   = 2126;
    localparam int unsigned LUMA_WEIGHT_GREEN = 7152;
    localparam int unsigned LUMA_WEIGHT_BLUE  = 722;
    localparam int unsigned LUMA_THRESHOLD    = 1270000;

    localparam int unsigned COLOR_W = 8;
    // 7152 * 255 needs 21 bits, the sum of three products 22 bits
    localparam int unsigned PROD_W  = 21;
    localparam int unsigned SUM_W   = 22;

    localparam int unsigned POS_W     = 2;
    localparam int unsigned PATTERN_W = 4;

    // basic scheme diagonals, bit set means white subpixel
    localparam logic [PATTERN_W-1:0] DIAG_MAIN  = 4'h9;
    localparam logic [PATTERN_W-1:0] DIAG_ANTI  = 4'h6;

    typedef enum logic {
        SCHEME_EXTENDED = 1'b0,
        SCHEME_BASIC    = 1'b1
    } t_scheme_mode;

    // load enables of the two luma stages
    typedef struct packed {
        logic adv_s1;
        logic adv_s2;
    } t_pipe_ctrl;

endpackage

/* src/vcsg_if.sv */
// ----------------------------------------------------------------------------
// vcsg_if
// valid/ready channels for pixel items and share items
// ----------------------------------------------------------------------------
interface vcsg_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] secret_red;
    logic [7:0] secret_green;
    logic [7:0] secret_blue;
    logic [7:0] cover_one_red;
    logic [7:0] cover_one_green;
    logic [7:0] cover_one_blue;
    logic [7:0] cover_two_red;
    logic [7:0] cover_two_green;
    logic [7:0] cover_two_blue;
    logic [1:0] random_first;
    logic [1:0] random_offset;
    logic [1:0] random_bits;

    modport source (
        output valid, secret_red, secret_green, secret_blue,
               cover_one_red, cover_one_green, cover_one_blue,
               cover_two_red, cover_two_green, cover_two_blue,
               random_first, random_offset, random_bits,
        input  ready
    );
    modport sink (
        input  valid, secret_red, secret_green, secret_blue,
               cover_one_red, cover_one_green, cover_one_blue,
               cover_two_red, cover_two_green, cover_two_blue,
               random_first, random_offset, random_bits,
        output ready
    );
endinterface

interface vcsg_share_if;
    logic       valid;
    logic       ready;
    logic [3:0] share_one_pattern;
    logic [3:0] share_two_pattern;
    logic       secret_is_black;
    logic       cover_one_is_black;
    logic       cover_two_is_black;

    modport source (
        output valid, share_one_pattern, share_two_pattern,
               secret_is_black, cover_one_is_black, cover_two_is_black,
        input  ready
    );
    modport sink (
        input  valid, share_one_pattern, share_two_pattern,
               secret_is_black, cover_one_is_black, cover_two_is_black,
        output ready
    );
endinterface

/* src/vcsg_luma.sv */
// ----------------------------------------------------------------------------
// vcsg_luma
// two-stage luma threshold test of one rgb pixel
// ----------------------------------------------------------------------------
module vcsg_luma (
    input  logic                                i_clk,
    input  vcsg_pkg::t_pipe_ctrl                i_ctrl,
    input  logic [vcsg_pkg::COLOR_W-1:0]        i_red,
    input  logic [vcsg_pkg::COLOR_W-1:0]        i_green,
    input  logic [vcsg_pkg::COLOR_W-1:0]        i_blue,
    output logic                                o_black
);

    logic [vcsg_pkg::PROD_W-1:0] r_prod_red;
    logic [vcsg_pkg::PROD_W-1:0] r_prod_green;
    logic [vcsg_pkg::PROD_W-1:0] r_prod_blue;
    logic [vcsg_pkg::SUM_W-1:0]  n_sum;
    logic                        r_black;

    // stage 1: constant weight products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv_s1) begin
            r_prod_red   <= vcsg_pkg::PROD_W'(i_red)
                            * vcsg_pkg::PROD_W'(vcsg_pkg::LUMA_WEIGHT_RED);
            r_prod_green <= vcsg_pkg::PROD_W'(i_green)
                            * vcsg_pkg::PROD_W'(vcsg_pkg::LUMA_WEIGHT_GREEN);
            r_prod_blue  <= vcsg_pkg::PROD_W'(i_blue)
                            * vcsg_pkg::PROD_W'(vcsg_pkg::LUMA_WEIGHT_BLUE);
        end
    end

    // stage 2: exact sum and compare
    assign n_sum = vcsg_pkg::SUM_W'(r_prod_red) + vcsg_pkg::SUM_W'(r_prod_green)
                 + vcsg_pkg::SUM_W'(r_prod_blue);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv_s2) begin
            r_black <= (n_sum < vcsg_pkg::SUM_W'(vcsg_pkg::LUMA_THRESHOLD));
        end
    end

    assign o_black = r_black;

endmodule

/* src/visual_crypto_share_generator_unit.sv */
// ----------------------------------------------------------------------------
// visual_crypto_share_generator_unit
// 2-of-2 visual cryptography share generator, when the output does not stall one pixel item per cycle
// ----------------------------------------------------------------------------
// Each item carries one rgb pixel of the secret and of two cover images plus
// random choices; each result carries two 2x2 share blocks (bit set = white
// subpixel) and the three black flags. A pixel is black when
// 2126r + 7152g + 722b < 1270000. The block takes a new item every cycle while
// the output is not stalled. Stage 1 forms the weight products at the edge
// that accepts the item, stage 2 sums and compares, and stage 3 builds the
// share patterns into the output register. Each stage holds its own valid
// bit and moves on whenever the stage after it is empty or moving, so a stall
// on the output fills the empty stages first and then holds the input off;
// nothing is dropped or repeated. scheme_mode (0 extended with covers, 1 basic)
// is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it only
// while no item is in flight, which the block itself does not enforce.
// There are no memories and no clearing pass after reset.
// ----------------------------------------------------------------------------
module visual_crypto_share_generator_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic                    i_cfg_wr_data,
    vcsg_pixel_if.sink              i_pix,
    vcsg_share_if.source            o_share
);

    // pipeline valid bits, stage 3 is the output register
    logic r_v1;
    logic r_v2;
    logic r_v3;

    // stage advance enables
    logic adv1;
    logic adv2;
    logic adv3;

    vcsg_pkg::t_pipe_ctrl   luma_ctrl;
    vcsg_pkg::t_scheme_mode r_scheme_mode;

    // random choices travel alongside the luma stages
    logic [vcsg_pkg::POS_W-1:0] r_s1_first;
    logic [vcsg_pkg::POS_W-1:0] r_s1_offset;
    logic [1:0]                 r_s1_bits;
    logic [vcsg_pkg::POS_W-1:0] r_s2_first;
    logic [vcsg_pkg::POS_W-1:0] r_s2_offset;
    logic [1:0]                 r_s2_bits;

    // black flags out of stage 2
    logic s2_secret_black;
    logic s2_cover_one_black;
    logic s2_cover_two_black;

    // output register
    logic [vcsg_pkg::PATTERN_W-1:0] r_o_share_one;
    logic [vcsg_pkg::PATTERN_W-1:0] r_o_share_two;
    logic                           r_o_secret_black;
    logic                           r_o_cover_one_black;
    logic                           r_o_cover_two_black;

    // stage 3 pattern logic
    logic [vcsg_pkg::POS_W-1:0]     offset_fix;
    logic [vcsg_pkg::POS_W-1:0]     pos_q;
    logic [vcsg_pkg::PATTERN_W-1:0] mask_p;
    logic [vcsg_pkg::PATTERN_W-1:0] mask_q;
    logic [vcsg_pkg::PATTERN_W-1:0] mask_rest;
    logic [vcsg_pkg::PATTERN_W-1:0] rest_lo;
    logic [vcsg_pkg::PATTERN_W-1:0] rest_hi;
    logic [vcsg_pkg::PATTERN_W-1:0] diag;
    logic [vcsg_pkg::PATTERN_W-1:0] n_share_one;
    logic [vcsg_pkg::PATTERN_W-1:0] n_share_two;

    // ---------------------------------------------------------------- control
    // a stage loads when it is empty or its contents move on this cycle
    assign adv3 = !r_v3 || o_share.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_pix.ready      = adv1;
    assign luma_ctrl.adv_s1 = adv1;
    assign luma_ctrl.adv_s2 = adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_pix.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // scheme register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme_mode <= vcsg_pkg::SCHEME_EXTENDED;
        end else if (i_cfg_wr_en) begin
            r_scheme_mode <= vcsg_pkg::t_scheme_mode'(i_cfg_wr_data);
        end
    end

    // ------------------------------------------------------ stages 1 and 2
    vcsg_luma u_luma_secret (
        .i_clk   (i_clk),
        .i_ctrl  (luma_ctrl),
        .i_red   (i_pix.secret_red),
        .i_green (i_pix.secret_green),
        .i_blue  (i_pix.secret_blue),
        .o_black (s2_secret_black)
    );

    vcsg_luma u_luma_cover_one (
        .i_clk   (i_clk),
        .i_ctrl  (luma_ctrl),
        .i_red   (i_pix.cover_one_red),
        .i_green (i_pix.cover_one_green),
        .i_blue  (i_pix.cover_one_blue),
        .o_black (s2_cover_one_black)
    );

    vcsg_luma u_luma_cover_two (
        .i_clk   (i_clk),
        .i_ctrl  (luma_ctrl),
        .i_red   (i_pix.cover_two_red),
        .i_green (i_pix.cover_two_green),
        .i_blue  (i_pix.cover_two_blue),
        .o_black (s2_cover_two_black)
    );

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_first  <= i_pix.random_first;
            r_s1_offset <= i_pix.random_offset;
            r_s1_bits   <= i_pix.random_bits;
        end
        if (adv2) begin
            r_s2_first  <= r_s1_first;
            r_s2_offset <= r_s1_offset;
            r_s2_bits   <= r_s1_bits;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // zero offset is taken as one so that q never equals p
    assign offset_fix = (r_s2_offset == '0) ? vcsg_pkg::POS_W'(1) : r_s2_offset;
    assign pos_q      = r_s2_first + offset_fix;
    assign mask_p     = vcsg_pkg::PATTERN_W'(1) << r_s2_first;
    assign mask_q     = vcsg_pkg::PATTERN_W'(1) << pos_q;
    assign mask_rest  = ~(mask_p | mask_q);
    // lowest and highest of the two positions outside {p,q}
    assign rest_lo    = mask_rest & (~mask_rest + vcsg_pkg::PATTERN_W'(1));
    assign rest_hi    = mask_rest & ~rest_lo;
    assign diag       = r_s2_bits[0] ? vcsg_pkg::DIAG_ANTI : vcsg_pkg::DIAG_MAIN;

    always_comb begin
        n_share_one = diag;
        n_share_two = diag;
        unique case (r_scheme_mode)
            vcsg_pkg::SCHEME_BASIC: begin
                // black secret gets complementary diagonals, white identical
                n_share_one = diag;
                n_share_two = s2_secret_black ? ~diag : diag;
            end
            vcsg_pkg::SCHEME_EXTENDED: begin
                if (s2_secret_black) begin
                    priority if (s2_cover_one_black && s2_cover_two_black) begin
                        n_share_one = mask_p;
                        n_share_two = mask_q;
                    end else if (s2_cover_one_black) begin
                        n_share_one = mask_p;
                        n_share_two = mask_rest;
                    end else if (s2_cover_two_black) begin
                        n_share_one = mask_rest;
                        n_share_two = mask_p;
                    end else begin
                        n_share_one = mask_p | mask_q;
                        n_share_two = mask_rest;
                    end
                end else begin
                    priority if (s2_cover_one_black && s2_cover_two_black) begin
                        n_share_one = mask_p;
                        n_share_two = mask_p;
                    end else if (s2_cover_one_black) begin
                        n_share_one = mask_p;
                        n_share_two = mask_p | mask_q;
                    end else if (s2_cover_two_black) begin
                        n_share_one = mask_p | mask_q;
                        n_share_two = mask_p;
                    end else begin
                        // one position outside {p,q} plus p or q
                        n_share_one = mask_p | mask_q;
                        n_share_two = (r_s2_bits[1] ? rest_hi : rest_lo)
                                    | (r_s2_bits[0] ? mask_q : mask_p);
                    end
                end
            end
            default: begin
                n_share_one = diag;
                n_share_two = diag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_o_share_one       <= n_share_one;
            r_o_share_two       <= n_share_two;
            r_o_secret_black    <= s2_secret_black;
            r_o_cover_one_black <= s2_cover_one_black;
            r_o_cover_two_black <= s2_cover_two_black;
        end
    end

    assign o_share.valid              = r_v3;
    assign o_share.share_one_pattern  = r_o_share_one;
    assign o_share.share_two_pattern  = r_o_share_two;
    assign o_share.secret_is_black    = r_o_secret_black;
    assign o_share.cover_one_is_black = r_o_cover_one_black;
    assign o_share.cover_two_is_black = r_o_cover_two_black;

`ifndef SYNTHESIS
    // stacking the shares hides every subpixel exactly when the secret is black
    a_stack_reveals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (((r_o_share_one & r_o_share_two) == '0) == r_o_secret_black))
        else $error("stacked shares disagree with secret flag");

    // every share block shows one or two white subpixels
    a_share_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (($countones(r_o_share_one) == 1 || $countones(r_o_share_one) == 2)
              && ($countones(r_o_share_two) == 1 || $countones(r_o_share_two) == 2)))
        else $error("share block white count out of range");

    // an accepted item always lands in stage 1
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v1)
        else $error("accepted item lost at stage 1");

    // input is held off only when every stage is occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with an empty stage");
`endif

endmodule
